### rtl/stpt_pkg.sv
package stpt_pkg;

  // Run length bound; the sample index saturates at the smaller of this minus one and 65535.
  localparam int unsigned MaxSamples = 65536;
  localparam int unsigned IdxLimitInt = ((MaxSamples - 1) < 65535) ? (MaxSamples - 1) : 65535;
  localparam logic [15:0] IdxLimit = 16'(IdxLimitInt);

  // Threshold reset levels in Q8.8: 9.81 and 5.0.
  localparam logic signed [15:0] HighThresholdReset = 16'sd2511;
  localparam logic signed [15:0] LowThresholdReset  = 16'sd1280;

  typedef enum logic {
    RegHighThreshold = 1'b0,
    RegLowThreshold  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [15:0] smoothed;
    logic [15:0]        sample_index;
    logic               exceeded;
    logic [14:0]        peak_value;
    logic [15:0]        peak_index;
    logic               run_last;
  } result_t;

endpackage

### rtl/smooth_threshold_peak_tracker.sv
// Smooths a run of signed Q8.8 samples with a [1,2,1]/4 kernel (edge samples use 3:1 weights,
// a single-sample run passes through), flags armed crossings of the high threshold with
// hysteresis, and tracks the run's peak and its index. One word is accepted per clock while
// in_stall_o is low; results lag the input by one sample. The last sample of a run with two or
// more samples yields two results: the second comes from the same result path in the next
// cycle that finds room in the output queue, and input stalls until then. Results pass through
// a two-word output queue, so input keeps flowing while one result waits. Threshold writes are
// taken at any edge with cfg_we_i high and apply to the following words.
module smooth_threshold_peak_tracker import stpt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] sample_i,
  input  logic               is_last_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] smoothed_o,
  output logic [15:0]        sample_index_o,
  output logic               exceeded_o,
  output logic [14:0]        peak_value_o,
  output logic [15:0]        peak_index_o,
  output logic               run_last_o
);

  logic signed [15:0] hi_q, lo_q;
  logic signed [15:0] held_q, held_d, prior_q, prior_d, peak_q, peak_d;
  logic [15:0]        pos_q, pos_d, peak_pos_q, peak_pos_d;
  logic               armed_q, armed_d, have_q, have_d, flush_q, flush_d;
  logic [1:0]         count_q, count_d;
  result_t            slot_q [2];
  result_t            slot_d [2];
  result_t            res;
  logic               push, pop, in_acc;

  assign in_stall_o  = flush_q || (count_q == 2'd2);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (count_q != 2'd0);
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    logic signed [17:0] h18, p18, s18, sum;
    logic signed [15:0] v;
    logic [15:0]        idx;
    logic               last, end_run, arm_tmp, exc;
    h18     = {{2{held_q[15]}}, held_q};
    p18     = {{2{prior_q[15]}}, prior_q};
    s18     = {{2{sample_i[15]}}, sample_i};
    sum     = '0;
    idx     = '0;
    last    = 1'b0;
    end_run = 1'b0;
    push    = 1'b0;
    held_d     = held_q;
    prior_d    = prior_q;
    pos_d      = pos_q;
    armed_d    = armed_q;
    peak_d     = peak_q;
    peak_pos_d = peak_pos_q;
    have_d     = have_q;
    flush_d    = flush_q;

    if (flush_q) begin
      // emit the trailing edge result once the queue has room
      if (count_q != 2'd2) begin
        sum     = p18 + (h18 <<< 1) + h18;
        idx     = pos_q;
        last    = 1'b1;
        push    = 1'b1;
        end_run = 1'b1;
      end
    end else if (in_acc) begin
      if (!have_q) begin
        if (is_last_i) begin
          sum     = s18 <<< 2;
          last    = 1'b1;
          push    = 1'b1;
          end_run = 1'b1;
        end else begin
          held_d  = sample_i;
          prior_d = '0;
          pos_d   = '0;
          have_d  = 1'b1;
        end
      end else begin
        if (pos_q == '0) sum = (h18 <<< 1) + h18 + s18;
        else             sum = p18 + (h18 <<< 1) + s18;
        idx     = pos_q;
        push    = 1'b1;
        prior_d = held_q;
        held_d  = sample_i;
        pos_d   = (pos_q < IdxLimit) ? pos_q + 16'd1 : pos_q;
        flush_d = is_last_i;
      end
    end

    v       = sum[17:2];
    arm_tmp = armed_q || (v < lo_q);
    exc     = arm_tmp && (v >= hi_q);
    if (push) begin
      armed_d = arm_tmp && !exc;
      if (v > peak_q) begin
        peak_d     = v;
        peak_pos_d = idx;
      end
    end
    res.smoothed     = v;
    res.sample_index = idx;
    res.exceeded     = exc;
    res.peak_value   = peak_d[14:0];
    res.peak_index   = peak_pos_d;
    res.run_last     = last;

    if (end_run) begin
      held_d     = '0;
      prior_d    = '0;
      pos_d      = '0;
      armed_d    = 1'b1;
      peak_d     = '0;
      peak_pos_d = '0;
      have_d     = 1'b0;
      flush_d    = 1'b0;
    end
  end

  // two-word output queue, slot 0 is the head
  always_comb begin
    slot_d[0] = slot_q[0];
    slot_d[1] = slot_q[1];
    count_d   = count_q;
    if (pop) begin
      slot_d[0] = slot_q[1];
      count_d   = count_d - 2'd1;
    end
    if (push) begin
      if (count_d == 2'd0) slot_d[0] = res;
      else                 slot_d[1] = res;
      count_d = count_d + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_q       <= HighThresholdReset;
      lo_q       <= LowThresholdReset;
      held_q     <= '0;
      prior_q    <= '0;
      pos_q      <= '0;
      armed_q    <= 1'b1;
      peak_q     <= '0;
      peak_pos_q <= '0;
      have_q     <= 1'b0;
      flush_q    <= 1'b0;
      count_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          RegHighThreshold: hi_q <= cfg_data_i;
          RegLowThreshold:  lo_q <= cfg_data_i;
          default: ;
        endcase
      end
      held_q     <= held_d;
      prior_q    <= prior_d;
      pos_q      <= pos_d;
      armed_q    <= armed_d;
      peak_q     <= peak_d;
      peak_pos_q <= peak_pos_d;
      have_q     <= have_d;
      flush_q    <= flush_d;
      count_q    <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q[0] <= slot_d[0];
    slot_q[1] <= slot_d[1];
  end

  assign smoothed_o     = slot_q[0].smoothed;
  assign sample_index_o = slot_q[0].sample_index;
  assign exceeded_o     = slot_q[0].exceeded;
  assign peak_value_o   = slot_q[0].peak_value;
  assign peak_index_o   = slot_q[0].peak_index;
  assign run_last_o     = slot_q[0].run_last;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("output queue count out of range");

  a_flush_has_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> have_q) else $error("flush pending without a held sample");

  a_flush_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flush_q && count_q != 2'd2) |=> !flush_q && !have_q && pos_q == '0)
    else $error("flush did not end the run");

  a_peak_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !peak_q[15]) else $error("peak went negative");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd2 && !pop) |=> count_q == 2'd2) else $error("push into full queue");

endmodule

### dv/smooth_threshold_peak_tracker_tb.sv
module smooth_threshold_peak_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stpt_pkg::*;

  typedef enum int {
    StyleFull,
    StyleNear,
    StyleExtreme
  } sample_style_e;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [15:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [15:0] sample_i;
  logic               is_last_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [15:0] smoothed_o;
  logic [15:0]        sample_index_o;
  logic               exceeded_o;
  logic [14:0]        peak_value_o;
  logic [15:0]        peak_index_o;
  logic               run_last_o;

  smooth_threshold_peak_tracker i_dut (.*);

  // Mirror of the block's state and thresholds.
  int          hi_thr = int'(HighThresholdReset);
  int          lo_thr = int'(LowThresholdReset);
  int          held_raw = 0;
  int          prev_raw = 0;
  int          run_pos = 0;
  bit          det_armed = 1'b1;
  int          run_peak = 0;
  logic [15:0] run_peak_pos = '0;
  bit          holding = 1'b0;

  result_t pending_results[$];

  bit in_quiet  = 1'b0;
  bit out_quiet = 1'b0;
  int words_left_in_run = 0;
  sample_style_e run_style = StyleFull;

  int n_words    = 0;
  int n_runs     = 0;
  int n_results  = 0;
  int n_exceeded = 0;
  int n_cfg      = 0;
  int n_errors   = 0;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  task automatic emit_smoothed(input int v, input logic [15:0] idx, input logic last);
    result_t r;
    r.exceeded = 1'b0;
    // Re-arm test comes before the exceedance test.
    if (v < lo_thr) det_armed = 1'b1;
    if (v >= hi_thr && det_armed) begin
      det_armed  = 1'b0;
      r.exceeded = 1'b1;
    end
    if (v > run_peak) begin
      run_peak     = v;
      run_peak_pos = idx;
    end
    r.smoothed     = v[15:0];
    r.sample_index = idx;
    r.peak_value   = run_peak[14:0];
    r.peak_index   = run_peak_pos;
    r.run_last     = last;
    pending_results.push_back(r);
  endtask

  task automatic clear_run();
    held_raw     = 0;
    prev_raw     = 0;
    run_pos      = 0;
    det_armed    = 1'b1;
    run_peak     = 0;
    run_peak_pos = '0;
    holding      = 1'b0;
  endtask

  task automatic smooth_and_track(input logic signed [15:0] s, input logic last);
    int cur;
    int v;
    cur = s;
    if (!holding) begin
      if (last) begin
        emit_smoothed(cur, 16'd0, 1'b1);
        clear_run();
      end else begin
        held_raw = cur;
        prev_raw = 0;
        run_pos  = 0;
        holding  = 1'b1;
      end
    end else begin
      if (run_pos == 0) v = (3 * held_raw + cur) >>> 2;
      else v = (prev_raw + 2 * held_raw + cur) >>> 2;
      emit_smoothed(v, run_pos[15:0], 1'b0);
      prev_raw = held_raw;
      held_raw = cur;
      if (run_pos < int'(IdxLimitInt)) run_pos++;
      if (last) begin
        // Flush the held sample with the trailing 1:3 weights.
        v = (prev_raw + 3 * held_raw) >>> 2;
        emit_smoothed(v, run_pos[15:0], 1'b1);
        clear_run();
      end
    end
  endtask

  task automatic send_word(input logic signed [15:0] s, input logic last);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 11);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    is_last_i  <= last;
    do @(posedge clk_i); while (in_stall_o);
    smooth_and_track(s, last);
    n_words++;
    if (last) n_runs++;
  endtask

  task automatic wait_for_idle();
    int waited;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_results.size() != 0) begin
      n_errors++;
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
    end
    // Let a word with no result of its own settle before touching the thresholds.
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic signed [15:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx == RegHighThreshold) hi_thr = val;
    else lo_thr = val;
    n_cfg++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_thresholds(input logic signed [15:0] hi, input logic signed [15:0] lo);
    write_reg(RegHighThreshold, hi);
    write_reg(RegLowThreshold, lo);
  endtask

  function automatic logic signed [15:0] pick_sample(input sample_style_e style);
    int v;
    if (style == StyleFull || $urandom_range(0, 7) == 0) begin
      v = $signed(16'($urandom));
    end else if (style == StyleNear) begin
      v = ($urandom_range(0, 1) == 1) ? hi_thr : lo_thr;
      v = v + int'($urandom_range(0, 1200)) - 600;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
    end else begin
      case ($urandom_range(0, 5))
        0: v = 32767;
        1: v = -32768;
        2: v = 0;
        3: v = -1;
        4: v = 1;
        default: v = 16383;
      endcase
    end
    return v[15:0];
  endfunction

  task automatic send_random_words(input int count);
    int i;
    int pick;
    for (i = 0; i < count; i++) begin
      if (words_left_in_run == 0) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) words_left_in_run = 1;
        else if (pick == 9) words_left_in_run = 2;
        else if (pick >= 7) words_left_in_run = $urandom_range(13, 40);
        else words_left_in_run = $urandom_range(2, 12);
        run_style = sample_style_e'($urandom_range(0, 2));
      end
      words_left_in_run--;
      send_word(pick_sample(run_style), words_left_in_run == 0);
    end
  endtask

  task automatic test_directed_runs();
    // Single-word runs pass straight through.
    send_word(16'sd32767, 1'b1);
    send_word(-16'sd32768, 1'b1);
    send_word(16'sd0, 1'b1);
    // Repeated high level: flag once, then stay disarmed.
    send_word(16'sd32767, 1'b0);
    send_word(16'sd32767, 1'b0);
    send_word(16'sd32767, 1'b1);
    // Dip below the low level between two crossings.
    send_word(16'sd3000, 1'b0);
    send_word(16'sd3000, 1'b0);
    send_word(16'sd0, 1'b0);
    send_word(16'sd0, 1'b0);
    send_word(16'sd3000, 1'b0);
    send_word(16'sd3000, 1'b1);
    // All-negative run keeps the peak at zero, index zero.
    send_word(-16'sd32768, 1'b0);
    send_word(-16'sd32768, 1'b1);
    // Alternating extremes through every kernel tap.
    send_word(-16'sd32768, 1'b0);
    send_word(16'sd32767, 1'b0);
    send_word(-16'sd32768, 1'b0);
    send_word(16'sd32767, 1'b1);
  endtask

  task automatic test_threshold_extremes();
    wait_for_idle();
    // Low above high: every value re-arms and flags.
    set_thresholds(-16'sd32768, 16'sd32767);
    send_word(16'sd100, 1'b0);
    send_word(-16'sd5, 1'b0);
    send_word(16'sd32767, 1'b0);
    send_word(-16'sd32768, 1'b1);
    send_word(16'sd7, 1'b1);
    wait_for_idle();
    // Only a full-scale value can cross; never re-arms.
    set_thresholds(16'sd32767, -16'sd32768);
    send_word(16'sd32767, 1'b0);
    send_word(16'sd32767, 1'b0);
    send_word(16'sd32767, 1'b1);
    send_word(16'sd32767, 1'b1);
  endtask

  task automatic test_random_runs();
    int phase;
    int hi;
    int lo;
    for (phase = 0; phase < 10; phase++) begin
      wait_for_idle();
      in_quiet  = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      hi = $urandom_range(0, 6000) - 1000;
      case ($urandom_range(0, 5))
        0: begin hi = int'(HighThresholdReset); lo = int'(LowThresholdReset); end
        1: begin hi = -32768; lo = 32767; end
        2: begin hi = 32767; lo = -32768; end
        3: lo = hi - int'($urandom_range(0, 3000));
        4: begin hi = $signed(16'($urandom)); lo = $signed(16'($urandom)); end
        default: lo = hi + int'($urandom_range(1, 2000));
      endcase
      set_thresholds(hi[15:0], lo[15:0]);
      // A phase may end mid-run; the next one carries on with it.
      send_random_words(150);
    end
    words_left_in_run = 1;
    send_word(pick_sample(StyleFull), 1'b1);
    in_quiet  = 1'b0;
    out_quiet = 1'b0;
  endtask

  task automatic test_back_to_back_run();
    int run_len;
    int i;
    run_len = 30;
    wait_for_idle();
    in_quiet  = 1'b1;
    out_quiet = 1'b1;
    set_thresholds(HighThresholdReset, LowThresholdReset);
    for (i = 0; i < run_len; i++) send_word(pick_sample(StyleNear), i == run_len - 1);
    wait_for_idle();
    in_quiet  = 1'b0;
    out_quiet = 1'b0;
  endtask

  initial begin
    result_t got;
    result_t want;
    int hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = out_quiet ? 0 : $urandom_range(0, 11);
      repeat (hold) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got.smoothed     = smoothed_o;
      got.sample_index = sample_index_o;
      got.exceeded     = exceeded_o;
      got.peak_value   = peak_value_o;
      got.peak_index   = peak_index_o;
      got.run_last     = run_last_o;
      n_results++;
      if (got.exceeded === 1'b1) n_exceeded++;
      if (pending_results.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result: expected none, got smoothed=%0d idx=%0d",
                 $time, got.smoothed, got.sample_index);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          n_errors++;
          $display({"%0t: mismatch: expected smoothed=%0d idx=%0d exc=%0b peak=%0d@%0d ",
                    "last=%0b, got smoothed=%0d idx=%0d exc=%0b peak=%0d@%0d last=%0b"},
                   $time, want.smoothed, want.sample_index, want.exceeded,
                   want.peak_value, want.peak_index, want.run_last,
                   got.smoothed, got.sample_index, got.exceeded,
                   got.peak_value, got.peak_index, got.run_last);
        end
      end
    end
  end

  initial begin
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = RegHighThreshold;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    sample_i   = '0;
    is_last_i  = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed_runs();
    test_threshold_extremes();
    test_random_runs();
    test_back_to_back_run();
    wait_for_idle();
    $display("covered %0d words in %0d runs under %0d threshold writes,", n_words, n_runs,
             n_cfg);
    $display("checked %0d results (%0d exceedances), including a run with no idle cycles",
             n_results, n_exceeded);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
